@@ hdl/jas_pkg.sv @@
// ----------------------------------------------------------------------------
// jas_pkg: shared types and constants for the JPEG APP1 segment stripper
// Parser modes, marker codes and the command record passed from the parser
// to the result sequencer.
// ----------------------------------------------------------------------------
package jas_pkg;

    // marker bytes
    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_SOS    = 8'hDA;
    localparam logic [7:0] MARK_EOI    = 8'hD9;
    localparam logic [7:0] MARK_APP1   = 8'hE1;

    // segment header is FF, marker, length high, length low
    localparam int unsigned HDR_BYTES = 4;

    // status codes carried by the final status result
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOT_JPEG = 2'd1;
    localparam logic [1:0] STAT_CORRUPT  = 2'd2;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // default depth of the command queue between parser and sequencer;
    // five covers a copied header draining while its body bytes arrive
    localparam int unsigned QUEUE_DEPTH_DEF = 5;

    // parser modes
    typedef enum logic [7:0] {
        MODE_SOI0      = 8'b0000_0001,
        MODE_SOI1      = 8'b0000_0010,
        MODE_HEADER    = 8'b0000_0100,
        MODE_COPY_BODY = 8'b0000_1000,
        MODE_SKIP_BODY = 8'b0001_0000,
        MODE_COPY_REST = 8'b0010_0000,
        MODE_SILENT    = 8'b0100_0000,
        MODE_NOT_JPEG  = 8'b1000_0000
    } mode_t;

    // one request from the parser: up to four data bytes, then optional status
    typedef struct packed {
        logic [2:0]      data_cnt;
        logic [3:0][7:0] data;
        logic            stat_flag;
        logic [1:0]      stat;
    } cmd_t;

endpackage

@@ hdl/jas_front.sv @@
// ----------------------------------------------------------------------------
// jas_front: byte parser
// Accepts one file byte per cycle unless the queue is full, tracks the segment
// structure and turns each byte into a command for the result sequencer.
// ----------------------------------------------------------------------------
module jas_front
    import jas_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic [31:0] file_length_reg;
    logic [31:0] pos_reg, pos_next;
    mode_t       mode_reg, mode_next;
    logic [1:0]  hdr_idx_reg, hdr_idx_next;
    logic [7:0]  held0_reg, held0_next;
    logic [7:0]  held1_reg, held1_next;
    logic [15:0] seg_rem_reg, seg_rem_next;
    logic        failed_reg, failed_next;

    logic        accept;
    logic        active;
    logic [31:0] bytes_left;
    logic [15:0] seg_len;
    logic        seg_overrun;
    cmd_t        cmd;

    assign s_ready    = !q_full;
    assign accept     = s_valid && s_ready;
    assign active     = pos_reg < file_length_reg;
    assign bytes_left = file_length_reg - pos_reg;
    assign seg_len    = {held1_reg, s_in_byte};
    // segment end (start + 2 + length) beyond the file
    assign seg_overrun = {17'b0, seg_len} > ({1'b0, bytes_left} + 33'd1);

    // parse step
    always_comb begin
        pos_next     = pos_reg;
        mode_next    = mode_reg;
        hdr_idx_next = hdr_idx_reg;
        held0_next   = held0_reg;
        held1_next   = held1_reg;
        seg_rem_next = seg_rem_reg;
        failed_next  = failed_reg;
        cmd          = '0;

        if (accept && active) begin
            unique case (mode_reg)
                MODE_SOI0: begin
                    if (file_length_reg < 32'(HDR_BYTES) || s_in_byte != MARK_PREFIX)
                        mode_next = MODE_NOT_JPEG;
                    else
                        mode_next = MODE_SOI1;
                end
                MODE_SOI1: begin
                    if (s_in_byte != MARK_SOI) begin
                        mode_next = MODE_NOT_JPEG;
                    end else begin
                        cmd.data_cnt = 3'd2;
                        cmd.data[0]  = MARK_PREFIX;
                        cmd.data[1]  = MARK_SOI;
                        mode_next    = MODE_HEADER;
                        hdr_idx_next = 2'd0;
                    end
                end
                MODE_HEADER: begin
                    unique case (hdr_idx_reg)
                        2'd0: begin
                            if (bytes_left < 32'(HDR_BYTES) || s_in_byte != MARK_PREFIX)
                                mode_next = MODE_SILENT;
                            else
                                hdr_idx_next = 2'd1;
                        end
                        2'd1: begin
                            held0_next   = s_in_byte;
                            hdr_idx_next = 2'd2;
                        end
                        2'd2: begin
                            held1_next   = s_in_byte;
                            hdr_idx_next = 2'd3;
                        end
                        default: begin
                            hdr_idx_next = 2'd0;
                            cmd.data[0]  = MARK_PREFIX;
                            cmd.data[1]  = held0_reg;
                            cmd.data[2]  = held1_reg;
                            cmd.data[3]  = s_in_byte;
                            if (seg_overrun) begin
                                failed_next = 1'b1;
                                mode_next   = MODE_SILENT;
                            end else if (held0_reg == MARK_SOS || held0_reg == MARK_EOI) begin
                                cmd.data_cnt = 3'd4;
                                mode_next    = MODE_COPY_REST;
                            end else if (seg_len < 16'd2) begin
                                failed_next = 1'b1;
                                mode_next   = MODE_SILENT;
                            end else begin
                                seg_rem_next = seg_len - 16'd2;
                                if (held0_reg != MARK_APP1)
                                    cmd.data_cnt = 3'd4;
                                if (seg_len == 16'd2)
                                    mode_next = MODE_HEADER;
                                else if (held0_reg == MARK_APP1)
                                    mode_next = MODE_SKIP_BODY;
                                else
                                    mode_next = MODE_COPY_BODY;
                            end
                        end
                    endcase
                end
                MODE_COPY_BODY, MODE_SKIP_BODY: begin
                    if (mode_reg == MODE_COPY_BODY) begin
                        cmd.data_cnt = 3'd1;
                        cmd.data[0]  = s_in_byte;
                    end
                    if (seg_rem_reg <= 16'd1) begin
                        seg_rem_next = '0;
                        mode_next    = MODE_HEADER;
                        hdr_idx_next = 2'd0;
                    end else begin
                        seg_rem_next = seg_rem_reg - 16'd1;
                    end
                end
                MODE_COPY_REST: begin
                    cmd.data_cnt = 3'd1;
                    cmd.data[0]  = s_in_byte;
                end
                MODE_SILENT, MODE_NOT_JPEG: begin
                end
                default: begin
                end
            endcase

            pos_next = pos_reg + 32'd1;
            // last byte of the file: append the status result
            if (bytes_left == 32'd1) begin
                cmd.stat_flag = 1'b1;
                if (mode_next == MODE_NOT_JPEG)
                    cmd.stat = STAT_NOT_JPEG;
                else if (failed_next)
                    cmd.stat = STAT_CORRUPT;
                else
                    cmd.stat = STAT_OK;
            end
        end
    end

    assign q_push = accept && active && (cmd.data_cnt != 3'd0 || cmd.stat_flag);
    assign q_cmd  = cmd;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_length_reg <= '0;
            pos_reg         <= '0;
            mode_reg        <= MODE_SOI0;
            hdr_idx_reg     <= '0;
            held0_reg       <= '0;
            held1_reg       <= '0;
            seg_rem_reg     <= '0;
            failed_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en)
                file_length_reg <= cfg_wr_data;
            pos_reg     <= pos_next;
            mode_reg    <= mode_next;
            hdr_idx_reg <= hdr_idx_next;
            held0_reg   <= held0_next;
            held1_reg   <= held1_next;
            seg_rem_reg <= seg_rem_next;
            failed_reg  <= failed_next;
        end
    end

endmodule

@@ hdl/jas_queue.sv @@
// ----------------------------------------------------------------------------
// jas_queue: command queue
// Small FIFO of parser commands so that the parser and the sequencer stall
// independently.
// ----------------------------------------------------------------------------
module jas_queue
    import jas_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic full,
    output logic empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push, do_pop;

    assign full     = cnt_reg == CNT_W'(DEPTH);
    assign empty    = cnt_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

endmodule

@@ hdl/jas_back.sv @@
// ----------------------------------------------------------------------------
// jas_back: result sequencer
// Walks the command at the head of the queue and presents its results one
// per cycle, while m_ready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module jas_back
    import jas_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       head_cmd,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_kind,
    output logic [1:0] m_status,
    output logic       m_run_last
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       kind_reg;
    logic [1:0] stat_reg;
    logic       last_reg;

    logic [2:0] total;
    logic       load;
    logic       is_data;
    logic       is_last;

    assign total   = head_cmd.data_cnt + {2'b0, head_cmd.stat_flag};
    assign load    = !q_empty && (!valid_reg || m_ready);
    assign is_data = idx_reg < head_cmd.data_cnt;
    assign is_last = idx_reg == (total - 3'd1);
    assign q_pop   = load && is_last;

    // position within the current request
    always_comb begin
        idx_next = idx_reg;
        if (load)
            idx_next = is_last ? 3'd0 : idx_reg + 3'd1;
    end

    // output stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (load)
                valid_reg <= 1'b1;
            else if (m_ready)
                valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= is_data ? head_cmd.data[idx_reg[1:0]] : 8'd0;
            kind_reg <= is_data ? KIND_DATA : KIND_STATUS;
            stat_reg <= is_data ? STAT_OK : head_cmd.stat;
            last_reg <= is_last;
        end
    end

    assign m_valid    = valid_reg;
    assign m_out_byte = byte_reg;
    assign m_kind     = kind_reg;
    assign m_status   = stat_reg;
    assign m_run_last = last_reg;

endmodule

@@ hdl/jpeg_app1_segment_stripper_core.sv @@
// ----------------------------------------------------------------------------
// jpeg_app1_segment_stripper_core: streaming JPEG APP1 segment remover
// Removes APP1 (EXIF) segments from a JPEG byte stream and reports a final
// status after the last byte of the file.
// ----------------------------------------------------------------------------
// Write file_length before streaming a file; reset restarts the parser. The
// parser takes one byte per cycle whenever the command queue has room and
// turns it into zero to five results (a header gives four bytes, the last
// byte adds the status result). The output stage sends one result per cycle
// while m_ready is high. The three header bytes ahead of a copied header
// give nothing, so with m_ready held high the queue (QUEUE_DEPTH requests,
// five by default) absorbs the drain of a header and bytes keep flowing at
// one per cycle; only a receiver holding m_ready low fills it and drops
// s_ready. Bytes sent past file_length are taken and dropped. No clearing
// pass after reset.
module jpeg_app1_segment_stripper_core
    import jas_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_kind,
    output logic [1:0]  m_status,
    output logic        m_run_last
);

    logic q_full, q_empty, q_push, q_pop;
    cmd_t push_cmd, head_cmd;

    // parser
    jas_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    // request queue
    jas_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // result sequencer
    jas_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_cmd   (head_cmd),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_kind     (m_kind),
        .m_status   (m_status),
        .m_run_last (m_run_last)
    );

endmodule

@@ hdl/jas_checker.sv @@
// ----------------------------------------------------------------------------
// jas_checker: port-level checks for the segment stripper
// Watches the result channel and flags malformed results.
// ----------------------------------------------------------------------------
module jas_checker
    import jas_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_kind,
    input logic [1:0] m_status,
    input logic       m_run_last
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_kind)
                                && $stable(m_status) && $stable(m_run_last))
        else $error("stalled result changed");

    // status result always closes the burst of its byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_STATUS |-> m_run_last && m_out_byte == 8'd0)
        else $error("status result not last or carries data");

    // data results carry ok status; status code within range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kind == KIND_DATA && m_status == STAT_OK)
                 || (m_kind == KIND_STATUS && m_status != 2'd3))
        else $error("bad status field");

    // nothing offered straight after reset
    assert property (@(posedge aclk)
        $past(aresetn) == 1'b0 |-> !m_valid)
        else $error("result valid after reset");

endmodule

bind jpeg_app1_segment_stripper_core jas_checker u_jas_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_kind     (m_kind),
    .m_status   (m_status),
    .m_run_last (m_run_last)
);

@@ bench/jas_stream_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jas_stream_checker: result predictor and comparator for the APP1 stripper
// Mirrors file_length from the configuration port, runs every byte the block
// takes through its own copy of the segment parser and compares each result
// that leaves the block, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module jas_stream_checker
    import jas_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_kind,
    input  logic [1:0]  m_status,
    input  logic        m_run_last,
    output int          n_pending,
    output int          n_fail,
    output int          n_results,
    output int          n_status
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       kind;
        logic [1:0] status;
        logic       run_last;
    } result_t;

    // results predicted but not yet seen on the output
    result_t due_results[$];

    // mirror of the parser state
    logic [31:0] file_len;
    logic [31:0] byte_pos;
    mode_t       mode;
    logic [1:0]  hdr_idx;
    logic [7:0]  hdr_marker;
    logic [7:0]  hdr_len_hi;
    logic [16:0] seg_left;
    logic        corrupt_seen;

    int fails    = 0;
    int results  = 0;
    int statuses = 0;

    function automatic result_t data_result(input logic [7:0] value);
        result_t r;
        r.out_byte = value;
        r.kind     = KIND_DATA;
        r.status   = STAT_OK;
        r.run_last = 1'b0;
        return r;
    endfunction

    // advance the parser by one byte and queue whatever it gives
    task automatic parse_in_byte(input logic [7:0] b);
        result_t     burst[$];
        result_t     r;
        logic [15:0] seg_len;
        logic [33:0] seg_end;
        logic        echo_hdr;
        echo_hdr = 1'b0;
        // past the end of the file: swallowed
        if (byte_pos >= file_len)
            return;
        case (mode)
            MODE_SOI0: begin
                if (file_len < HDR_BYTES || b != MARK_PREFIX)
                    mode = MODE_NOT_JPEG;
                else
                    mode = MODE_SOI1;
            end
            MODE_SOI1: begin
                if (b != MARK_SOI) begin
                    mode = MODE_NOT_JPEG;
                end else begin
                    burst   = {burst, data_result(MARK_PREFIX)};
                    burst   = {burst, data_result(MARK_SOI)};
                    mode    = MODE_HEADER;
                    hdr_idx = 2'd0;
                end
            end
            MODE_HEADER: begin
                case (hdr_idx)
                    2'd0: begin
                        // need the prefix and room for a whole header
                        if (file_len - byte_pos < HDR_BYTES || b != MARK_PREFIX)
                            mode = MODE_SILENT;
                        else
                            hdr_idx = 2'd1;
                    end
                    2'd1: begin
                        hdr_marker = b;
                        hdr_idx    = 2'd2;
                    end
                    2'd2: begin
                        hdr_len_hi = b;
                        hdr_idx    = 2'd3;
                    end
                    default: begin
                        seg_len = {hdr_len_hi, b};
                        // segment starts three bytes back; end = start + 2 + length
                        seg_end = {2'b00, byte_pos} + {18'd0, seg_len} - 34'd1;
                        hdr_idx = 2'd0;
                        if (seg_end > {2'b00, file_len}) begin
                            corrupt_seen = 1'b1;
                            mode         = MODE_SILENT;
                        end else if (hdr_marker == MARK_SOS || hdr_marker == MARK_EOI) begin
                            echo_hdr = 1'b1;
                            mode     = MODE_COPY_REST;
                        end else if (seg_len < 16'd2) begin
                            corrupt_seen = 1'b1;
                            mode         = MODE_SILENT;
                        end else begin
                            seg_left = {1'b0, seg_len - 16'd2};
                            echo_hdr = (hdr_marker != MARK_APP1);
                            if (seg_left == '0)
                                mode = MODE_HEADER;
                            else if (hdr_marker == MARK_APP1)
                                mode = MODE_SKIP_BODY;
                            else
                                mode = MODE_COPY_BODY;
                        end
                    end
                endcase
            end
            MODE_COPY_BODY, MODE_SKIP_BODY: begin
                if (mode == MODE_COPY_BODY)
                    burst = {burst, data_result(b)};
                if (seg_left != '0)
                    seg_left = seg_left - 17'd1;
                if (seg_left == '0) begin
                    mode    = MODE_HEADER;
                    hdr_idx = 2'd0;
                end
            end
            MODE_COPY_REST: burst = {burst, data_result(b)};
            default: ;
        endcase

        if (echo_hdr) begin
            burst = {burst, data_result(MARK_PREFIX)};
            burst = {burst, data_result(hdr_marker)};
            burst = {burst, data_result(hdr_len_hi)};
            burst = {burst, data_result(b)};
        end

        byte_pos = byte_pos + 32'd1;
        // last byte of the file: closing status
        if (byte_pos == file_len) begin
            r.out_byte = 8'd0;
            r.kind     = KIND_STATUS;
            r.run_last = 1'b0;
            if (mode == MODE_NOT_JPEG)
                r.status = STAT_NOT_JPEG;
            else if (corrupt_seen)
                r.status = STAT_CORRUPT;
            else
                r.status = STAT_OK;
            burst = {burst, r};
        end

        if (burst.size() > 0)
            burst[burst.size() - 1].run_last = 1'b1;
        due_results = {due_results, burst};
    endtask

    // watch both channels and the config port
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            file_len     = '0;
            byte_pos     = '0;
            mode         = MODE_SOI0;
            hdr_idx      = '0;
            hdr_marker   = '0;
            hdr_len_hi   = '0;
            seg_left     = '0;
            corrupt_seen = 1'b0;
            due_results.delete();
        end else begin
            if (cfg_wr_en)
                file_len = cfg_wr_data;
            if (s_valid && s_ready)
                parse_in_byte(s_in_byte);
            if (m_valid && m_ready) begin
                results++;
                if (m_kind == KIND_STATUS)
                    statuses++;
                if (due_results.size() == 0) begin
                    $error("unexpected result: out_byte 0x%02h kind %0d status %0d run_last %0d",
                           m_out_byte, m_kind, m_status, m_run_last);
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    if (m_out_byte !== want.out_byte) begin
                        $error("m_out_byte: expected 0x%02h, got 0x%02h",
                               want.out_byte, m_out_byte);
                        fails++;
                    end
                    if (m_kind !== want.kind) begin
                        $error("m_kind: expected %0d, got %0d", want.kind, m_kind);
                        fails++;
                    end
                    if (m_status !== want.status) begin
                        $error("m_status: expected %0d, got %0d", want.status, m_status);
                        fails++;
                    end
                    if (m_run_last !== want.run_last) begin
                        $error("m_run_last: expected %0d, got %0d", want.run_last, m_run_last);
                        fails++;
                    end
                end
            end
        end
        n_pending <= due_results.size();
        n_fail    <= fails;
        n_results <= results;
        n_status  <= statuses;
    end

endmodule

@@ bench/jpeg_app1_segment_stripper_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_app1_segment_stripper_core_tb: stream test for the APP1 stripper
// Feeds JPEG-like byte streams, growing file_length at segment boundaries
// so the parser sees many segments after one reset. Now and then a broken
// opening is tried first and the block is reset before the good stream; a
// random closing case (copy to end, overrun, bad length, lost prefix, short
// tail) is picked per seed; both channels stall at random.
// ----------------------------------------------------------------------------
module jpeg_app1_segment_stripper_core_tb;
    import jas_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int SETTLE       = 16;    // quiet cycles before touching config
    localparam int STALL_LIMIT  = 2000;  // cycles without any request moving
    localparam int RANDOM_BYTES = 225;
    localparam int HOLD_CYCLES  = 200;   // long receiver hold-off

    typedef enum int {
        OPEN_GOOD, OPEN_SHORT, OPEN_BAD_PREFIX, OPEN_BAD_SOI
    } opening_t;

    typedef enum int {
        END_NONE, END_COPY_REST, END_PAST_END, END_SHORT_LENGTH, END_NO_PREFIX, END_TOO_FEW
    } ending_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_kind;
    logic [1:0]  m_status;
    logic        m_run_last;

    int n_pending;
    int n_fail;
    int n_results;
    int n_status;

    logic [7:0]  chunk[$];     // bytes of the next length phase
    logic [31:0] stream_pos;   // bytes counted against file_length so far
    int          settings;
    logic        no_gaps;
    logic        hold_arm;     // start the hold-off with the next phase
    logic        hold_req;
    logic        hold_taken;
    int          idle_cycles;

    jpeg_app1_segment_stripper_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_kind     (m_kind),
        .m_status   (m_status),
        .m_run_last (m_run_last)
    );

    jas_stream_checker stream_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_kind     (m_kind),
        .m_status   (m_status),
        .m_run_last (m_run_last),
        .n_pending  (n_pending),
        .n_fail     (n_fail),
        .n_results  (n_results),
        .n_status   (n_status)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // APP1 about a third of the time, otherwise any plain marker
    function automatic logic [7:0] pick_marker();
        logic [7:0] mk;
        if ($urandom_range(0, 99) < 35)
            return MARK_APP1;
        do
            mk = rand_byte();
        while (mk == MARK_SOS || mk == MARK_EOI || mk == MARK_APP1);
        return mk;
    endfunction

    // body sizes: mostly tiny, some medium, rarely past 255
    function automatic int pick_body();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(0, 8);
        if (r < 98)
            return $urandom_range(9, 40);
        return $urandom_range(256, 280);
    endfunction

    // append one byte to the next phase
    task automatic add_byte(input logic [7:0] b);
        chunk = {chunk, b};
    endtask

    task automatic add_segment(input logic [7:0] mk, input int body);
        logic [15:0] len;
        len = body[15:0] + 16'd2;
        add_byte(MARK_PREFIX);
        add_byte(mk);
        add_byte(len[15:8]);
        add_byte(len[7:0]);
        repeat (body) add_byte(rand_byte());
    endtask

    // offer one byte and hold it until taken
    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drain everything due, then let the block settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_length(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        settings++;
    endtask

    // extend the file by the queued chunk and stream it
    task automatic send_chunk();
        wait_idle();
        write_length(stream_pos + chunk.size());
        // the receiver's long hold-off starts as this phase begins
        if (hold_arm) begin
            hold_req <= 1'b1;
            hold_arm = 1'b0;
        end
        no_gaps = ($urandom_range(0, 3) == 0);
        foreach (chunk[i]) push_byte(chunk[i]);
        stream_pos = stream_pos + chunk.size();
        // a few bytes past the end now and then; the block must swallow them
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) push_byte(rand_byte());
        chunk.delete();
    endtask

    // receiver: random ready with steady stretches and one long hold-off
    initial begin : rx_side
        int gap;
        int stay;
        hold_taken = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    for (int c = 0; c < gap && !(hold_req && !hold_taken); c++)
                        @(posedge aclk);
                end
                if (!(hold_req && !hold_taken)) begin
                    m_ready <= 1'b1;
                    stay = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                       : $urandom_range(1, 6);
                    for (int c = 0; c < stay && !(hold_req && !hold_taken); c++)
                        @(posedge aclk);
                end
            end
        end
    end

    // watchdog: nothing moving on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $error("no request moved for %0d cycles, %0d results still due",
                   STALL_LIMIT, n_pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // stimulus and verdict
    initial begin
        opening_t    opening;
        ending_t     ending;
        int          k;
        int          start_len;
        logic [15:0] len;
        logic [7:0]  mk;
        logic [31:0] random_start;

        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_in_byte   <= '0;
        hold_req    <= 1'b0;
        stream_pos  = '0;
        settings    = 0;
        no_gaps     = 1'b0;
        hold_arm    = 1'b0;
        ending      = END_NONE;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero length: bytes must be dropped without a result
        write_length(32'd0);
        push_byte(8'hFF);
        push_byte(8'hD8);

        // now and then a broken opening; the parser stays locked until reset
        k = $urandom_range(0, 9);
        opening = (k < 7) ? OPEN_GOOD : opening_t'(k - 6);
        if (opening != OPEN_GOOD) begin
            case (opening)
                OPEN_SHORT: begin
                    // whole file below a header's size
                    start_len = $urandom_range(1, 3);
                    add_byte(MARK_PREFIX);
                    if (start_len > 1) add_byte(MARK_SOI);
                    if (start_len > 2) add_byte(rand_byte());
                end
                OPEN_BAD_PREFIX: begin
                    add_byte(8'($urandom_range(0, 254)));
                    add_byte(MARK_SOI);
                    repeat ($urandom_range(2, 6)) add_byte(rand_byte());
                end
                default: begin
                    add_byte(MARK_PREFIX);
                    do mk = rand_byte(); while (mk == MARK_SOI);
                    add_byte(mk);
                    repeat ($urandom_range(2, 6)) add_byte(rand_byte());
                end
            endcase
            send_chunk();

            // restart the stream from reset
            wait_idle();
            aresetn <= 1'b0;
            repeat (6) @(posedge aclk);
            aresetn <= 1'b1;
            @(posedge aclk);
            stream_pos = '0;
        end

        // good opening of the stream
        chunk = {8'hFF, 8'hD8,
                 8'hFF, 8'hE0, 8'h00, 8'h05, 8'h00, 8'hFF, 8'h80,
                 8'hFF, 8'hE1, 8'h00, 8'h04, 8'h12, 8'h34,
                 8'hFF, 8'hE1, 8'h00, 8'h02,
                 8'hFF, 8'hFE, 8'h00, 8'h02};
        send_chunk();

        random_start = stream_pos;
        hold_arm     = 1'b1;

        // first random phase is copied whole so the block backs up during the hold
        repeat (4) begin
            do mk = pick_marker(); while (mk == MARK_APP1);
            add_segment(mk, $urandom_range(4, 8));
        end
        send_chunk();

        // well-formed segments, file grown a few segments at a time
        while (stream_pos - random_start < RANDOM_BYTES - 40) begin
            repeat ($urandom_range(1, 3)) add_segment(pick_marker(), pick_body());
            send_chunk();
            // length set at or below the current position: byte ignored
            if ($urandom_range(0, 7) == 0) begin
                wait_idle();
                write_length($urandom_range(0, stream_pos));
                push_byte(rand_byte());
            end
        end

        // one closing case per run
        ending = ending_t'($urandom_range(1, 5));
        k = $urandom_range(0, 6);
        mk = '0;
        len = '0;
        case (ending)
            END_COPY_REST: begin
                mk  = $urandom_range(0, 1) ? MARK_SOS : MARK_EOI;
                len = 16'($urandom_range(0, k + 2));
            end
            END_PAST_END: begin
                mk  = pick_marker();
                len = 16'($urandom_range(k + 3, 65535));
            end
            END_SHORT_LENGTH: begin
                mk  = $urandom_range(0, 1) ? MARK_APP1 : pick_marker();
                len = 16'($urandom_range(0, 1));
            end
            default: ;
        endcase
        if (ending == END_NO_PREFIX) begin
            add_byte(8'($urandom_range(0, 254)));
            repeat (k) add_byte(rand_byte());
        end else if (ending == END_TOO_FEW) begin
            add_byte($urandom_range(0, 1) ? MARK_PREFIX : rand_byte());
            repeat ($urandom_range(0, 2)) add_byte(rand_byte());
        end else begin
            add_byte(MARK_PREFIX);
            add_byte(mk);
            add_byte(len[15:8]);
            add_byte(len[7:0]);
            repeat (k) add_byte(rand_byte());
        end
        send_chunk();

        // raw bytes in small phases: one status result per phase
        while (stream_pos - random_start < RANDOM_BYTES) begin
            repeat ($urandom_range(1, 6)) add_byte(rand_byte());
            send_chunk();
        end

        // largest length: no closing status within reach
        wait_idle();
        write_length(32'hFFFF_FFFF);
        repeat (4) push_byte(rand_byte());
        wait_idle();

        $display("Streamed %0d file bytes over %0d length settings; opening %s, close %s",
                 stream_pos, settings, opening.name(), ending.name());
        $display("Checked %0d results, %0d of them status results",
                 n_results, n_status);
        if (n_fail == 0 && n_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
